// ===== rtl/tita_pkg.sv =====
package tita_pkg;

    localparam int TASK_SLOTS = 32;
    localparam int IRQ_LINES  = 64;
    localparam int TASK_IDX_W = $clog2(TASK_SLOTS);
    localparam int IRQ_IDX_W  = $clog2(IRQ_LINES);

    localparam int OP_W   = 3;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 5;
    localparam int LINE_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_START      = 3'd0,
        OP_STOP       = 3'd1,
        OP_SWITCH     = 3'd2,
        OP_IRQ_ENTRY  = 3'd3,
        OP_IRQ_EXIT   = 3'd4,
        OP_READ_TASK  = 3'd5,
        OP_READ_IRQ   = 3'd6,
        OP_READ_TOTAL = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELTA,
        ST_ACCUM,
        ST_COMMIT
    } state_t;

    // control word for the shared adder
    typedef struct packed {
        logic en;
        logic sub;
    } alu_ctl_t;

endpackage

// ===== rtl/tita_in_if.sv =====
interface tita_in_if;
    logic                          valid;
    logic                          ready;
    logic [tita_pkg::OP_W-1:0]     operation;
    logic [tita_pkg::TIME_W-1:0]   timestamp_us;
    logic [tita_pkg::SLOT_W-1:0]   task_slot;
    logic [tita_pkg::LINE_W-1:0]   irq_number;

    modport source (output valid, operation, timestamp_us, task_slot, irq_number,
                    input ready);
    modport sink   (input valid, operation, timestamp_us, task_slot, irq_number,
                    output ready);
endinterface

// ===== rtl/tita_out_if.sv =====
interface tita_out_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [tita_pkg::TIME_W-1:0]   value;

    modport source (output valid, status, value, input ready);
    modport sink   (input valid, status, value, output ready);
endinterface

// ===== rtl/tita_alu.sv =====
module tita_alu (
    input  logic                        clk,
    input  tita_pkg::alu_ctl_t          ctl,
    input  logic [tita_pkg::TIME_W-1:0] a,
    input  logic [tita_pkg::TIME_W-1:0] b,
    output logic [tita_pkg::TIME_W-1:0] q
);

    logic [tita_pkg::TIME_W-1:0] q_reg;
    logic [tita_pkg::TIME_W-1:0] q_next;

    // wraps modulo 2^32 by construction
    always_comb
    begin
        if (ctl.sub)
        begin
            q_next = a - b;
        end
        else
        begin
            q_next = a + b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/task_irq_time_accounting_core.sv =====
// Task and interrupt time accounting. Each input word is one scheduler or
// interrupt event stamped with a free-running 32-bit microsecond time; every
// event returns exactly one result word (status, value). Start clears all
// per-task and per-interrupt accumulators at once through per-entry valid
// bits, so there is no clearing sweep and start costs no more than any other
// event. Switch and irq entry charge the time since the previous charge to the
// running task, irq exit charges it to the active interrupt; the first charge
// after start is zero and all arithmetic wraps modulo 2^32. Reads answer
// whether or not a session is active. Timing: the block captures an event and
// reads both accumulator stores at the accepting edge, then is busy through
// three steps (difference, add, commit) around one shared 32-bit adder; a new
// event is accepted only after the commit step of the last one. A finished
// result waits in the output register; the next event may be accepted and
// worked on meanwhile, and only its commit step holds until the output
// register is taken.
module task_irq_time_accounting_core (
    input  logic       clk,
    input  logic       rst_n,
    tita_in_if.sink    in_ch,
    tita_out_if.source out_ch
);

    // sequencer
    tita_pkg::state_t state_reg;
    tita_pkg::state_t state_next;

    // captured event
    tita_pkg::op_t                    op_reg;
    logic [tita_pkg::TIME_W-1:0]      ts_reg;
    logic [tita_pkg::TASK_IDX_W-1:0]  slot_reg;
    logic [tita_pkg::IRQ_IDX_W-1:0]   line_reg;

    // session state
    logic                             armed_reg;
    logic [tita_pkg::TIME_W-1:0]      start_reg;
    logic [tita_pkg::TIME_W-1:0]      stop_reg;
    logic [tita_pkg::TIME_W-1:0]      prior_time_reg;
    logic                             prior_valid_reg;
    logic [tita_pkg::TASK_IDX_W-1:0]  running_reg;
    logic                             in_int_reg;
    logic [tita_pkg::IRQ_IDX_W-1:0]   active_irq_reg;

    // accumulator stores; an entry whose valid bit is clear reads as zero
    logic [tita_pkg::TIME_W-1:0]      task_mem [tita_pkg::TASK_SLOTS];
    logic [tita_pkg::TIME_W-1:0]      irq_mem  [tita_pkg::IRQ_LINES];
    logic [tita_pkg::TASK_SLOTS-1:0]  task_vld_reg;
    logic [tita_pkg::IRQ_LINES-1:0]   irq_vld_reg;
    logic [tita_pkg::TIME_W-1:0]      task_rd_reg;
    logic [tita_pkg::TIME_W-1:0]      irq_rd_reg;
    logic                             task_rd_vld_reg;
    logic                             irq_rd_vld_reg;

    // output register
    logic                             out_valid_reg;
    logic                             out_status_reg;
    logic [tita_pkg::TIME_W-1:0]      out_value_reg;

    // control
    logic                             in_fire;
    logic                             commit_go;
    logic                             charge_en;
    logic                             is_read;
    logic                             use_irq;
    logic [tita_pkg::TASK_IDX_W-1:0]  task_raddr;
    logic [tita_pkg::IRQ_IDX_W-1:0]   irq_raddr;
    logic [tita_pkg::TIME_W-1:0]      mem_val;
    tita_pkg::alu_ctl_t               alu_ctl;
    logic [tita_pkg::TIME_W-1:0]      alu_a;
    logic [tita_pkg::TIME_W-1:0]      alu_b;
    logic [tita_pkg::TIME_W-1:0]      alu_q;

    assign in_fire = in_ch.valid && in_ch.ready;

    // pick the accumulator that the event touches; reads use the item's own index
    assign task_raddr = (tita_pkg::op_t'(in_ch.operation) == tita_pkg::OP_READ_TASK)
                        ? in_ch.task_slot[tita_pkg::TASK_IDX_W-1:0] : running_reg;
    assign irq_raddr  = (tita_pkg::op_t'(in_ch.operation) == tita_pkg::OP_READ_IRQ)
                        ? in_ch.irq_number[tita_pkg::IRQ_IDX_W-1:0] : active_irq_reg;

    assign use_irq = (op_reg == tita_pkg::OP_IRQ_EXIT) || (op_reg == tita_pkg::OP_READ_IRQ);
    assign is_read = (op_reg == tita_pkg::OP_READ_TASK) || (op_reg == tita_pkg::OP_READ_IRQ)
                     || (op_reg == tita_pkg::OP_READ_TOTAL);
    assign mem_val = use_irq ? (irq_rd_vld_reg ? irq_rd_reg : '0)
                             : (task_rd_vld_reg ? task_rd_reg : '0);

    // an exit while not in an interrupt charges nothing
    assign charge_en = armed_reg && ((op_reg == tita_pkg::OP_SWITCH)
                       || (op_reg == tita_pkg::OP_IRQ_ENTRY)
                       || ((op_reg == tita_pkg::OP_IRQ_EXIT) && in_int_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tita_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = tita_pkg::ST_DELTA;
                end
            end
            tita_pkg::ST_DELTA:  state_next = tita_pkg::ST_ACCUM;
            tita_pkg::ST_ACCUM:  state_next = tita_pkg::ST_COMMIT;
            tita_pkg::ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = tita_pkg::ST_IDLE;
                end
            end
            default:             state_next = tita_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        commit_go   = 1'b0;
        alu_ctl     = '0;
        alu_a       = ts_reg;
        alu_b       = ts_reg;
        unique case (state_reg)
            tita_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            tita_pkg::ST_DELTA:
            begin
                // elapsed time: session length for read total, else since the prior charge
                alu_ctl.en  = 1'b1;
                alu_ctl.sub = 1'b1;
                if (op_reg == tita_pkg::OP_READ_TOTAL)
                begin
                    alu_a = armed_reg ? ts_reg : stop_reg;
                    alu_b = start_reg;
                end
                else
                begin
                    alu_a = ts_reg;
                    alu_b = prior_valid_reg ? prior_time_reg : ts_reg;
                end
            end
            tita_pkg::ST_ACCUM:
            begin
                // charge: old + delta; read task/irq: old + 0; read total: 0 + length
                alu_ctl.en  = 1'b1;
                alu_ctl.sub = 1'b0;
                alu_a = (op_reg == tita_pkg::OP_READ_TOTAL) ? '0 : mem_val;
                alu_b = ((op_reg == tita_pkg::OP_READ_TASK) || (op_reg == tita_pkg::OP_READ_IRQ))
                        ? '0 : alu_q;
            end
            tita_pkg::ST_COMMIT:
            begin
                commit_go = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    tita_alu u_alu (
        .clk (clk),
        .ctl (alu_ctl),
        .a   (alu_a),
        .b   (alu_b),
        .q   (alu_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tita_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture the event and read both accumulator stores
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg          <= tita_pkg::op_t'(in_ch.operation);
            ts_reg          <= in_ch.timestamp_us;
            slot_reg        <= in_ch.task_slot[tita_pkg::TASK_IDX_W-1:0];
            line_reg        <= in_ch.irq_number[tita_pkg::IRQ_IDX_W-1:0];
            task_rd_reg     <= task_mem[task_raddr];
            irq_rd_reg      <= irq_mem[irq_raddr];
            task_rd_vld_reg <= task_vld_reg[task_raddr];
            irq_rd_vld_reg  <= irq_vld_reg[irq_raddr];
        end
    end

    // write back the charged accumulator
    always_ff @(posedge clk)
    begin
        if (commit_go && charge_en)
        begin
            if (op_reg == tita_pkg::OP_IRQ_EXIT)
            begin
                irq_mem[active_irq_reg] <= alu_q;
            end
            else
            begin
                task_mem[running_reg] <= alu_q;
            end
        end
    end

    // session state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            start_reg       <= '0;
            stop_reg        <= '0;
            prior_time_reg  <= '0;
            prior_valid_reg <= 1'b0;
            running_reg     <= '0;
            in_int_reg      <= 1'b0;
            active_irq_reg  <= '0;
            task_vld_reg    <= '0;
            irq_vld_reg     <= '0;
        end
        else if (commit_go)
        begin
            if (charge_en)
            begin
                prior_time_reg  <= ts_reg;
                prior_valid_reg <= 1'b1;
                if (op_reg == tita_pkg::OP_IRQ_EXIT)
                begin
                    irq_vld_reg[active_irq_reg] <= 1'b1;
                end
                else
                begin
                    task_vld_reg[running_reg] <= 1'b1;
                end
            end
            unique case (op_reg)
                tita_pkg::OP_START:
                begin
                    // restart the session; interrupt state stays as it is
                    task_vld_reg    <= '0;
                    irq_vld_reg     <= '0;
                    prior_valid_reg <= 1'b0;
                    prior_time_reg  <= '0;
                    stop_reg        <= '0;
                    start_reg       <= ts_reg;
                    running_reg     <= slot_reg;
                    armed_reg       <= 1'b1;
                end
                tita_pkg::OP_STOP:
                begin
                    if (armed_reg)
                    begin
                        stop_reg  <= ts_reg;
                        armed_reg <= 1'b0;
                    end
                end
                tita_pkg::OP_SWITCH:
                begin
                    if (charge_en)
                    begin
                        running_reg <= slot_reg;
                    end
                end
                tita_pkg::OP_IRQ_ENTRY:
                begin
                    if (charge_en)
                    begin
                        active_irq_reg <= line_reg;
                        in_int_reg     <= 1'b1;
                    end
                end
                tita_pkg::OP_IRQ_EXIT:
                begin
                    if (charge_en)
                    begin
                        in_int_reg  <= 1'b0;
                        running_reg <= slot_reg;
                    end
                end
                default:
                begin
                    // reads leave the state alone
                    in_int_reg <= in_int_reg;
                end
            endcase
        end
    end

    // output register: load on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
        begin
            out_status_reg <= (op_reg == tita_pkg::OP_STOP) && !armed_reg;
            out_value_reg  <= is_read ? alu_q : '0;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.value  = out_value_reg;

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_go && (op_reg == tita_pkg::OP_START))
        |=> (armed_reg && !prior_valid_reg && (task_vld_reg == '0)))
        else $error("start did not arm and clear the session");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(commit_go))
        else $error("result appeared without a commit");

    a_status_only_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_go && (op_reg != tita_pkg::OP_STOP)) |=> !out_status_reg)
        else $error("status set for an operation other than stop");

    a_int_clear_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_int_reg) |-> $past(commit_go && (op_reg == tita_pkg::OP_IRQ_EXIT)))
        else $error("interrupt flag cleared outside an irq exit");

    a_no_commit_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !commit_go)
        else $error("commit overwrote a pending result");

endmodule
